[hw/rtl/tns_pkg.sv]
// package for the tune note sequencer: codes, tune table and note helpers
package tns_pkg;

    localparam int TUNE_LENGTH = 21;
    localparam int ROM_ENTRIES = 21;
    localparam int POS_W       = 5;
    localparam int HOLD_W      = 32;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_STOP   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_SILENCE = 2'd2
    } t_action;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] elapsed;
    } t_item;

    typedef struct packed {
        logic [8:0]        period;
        logic signed [2:0] octave;
        logic [7:0]        duration;
    } t_entry;

    // fixed tune; positions past the table read as an all-zero entry
    function automatic t_entry tune_entry(input logic [POS_W-1:0] pos);
        t_entry e;
        e = '0;
        if (int'(pos) < ROM_ENTRIES) begin
            unique case (pos)
                5'd0:    e = '{9'd253, 3'sd2, 8'd210};
                5'd1:    e = '{9'd284, 3'sd3, 8'd210};
                5'd2:    e = '{9'd451, 3'sd2, 8'd210};
                5'd3:    e = '{9'd268, 3'sd1, 8'd210};
                5'd4:    e = '{9'd253, 3'sd2, 8'd140};
                5'd5:    e = '{9'd284, 3'sd3, 8'd140};
                5'd6:    e = '{9'd451, 3'sd2, 8'd140};
                5'd7:    e = '{9'd268, 3'sd1, 8'd140};
                5'd8:    e = '{9'd253, 3'sd2, 8'd70};
                5'd9:    e = '{9'd284, 3'sd3, 8'd70};
                5'd10:   e = '{9'd451, 3'sd2, 8'd70};
                5'd11:   e = '{9'd268, 3'sd1, 8'd70};
                5'd12:   e = '{9'd253, 3'sd2, 8'd35};
                5'd13:   e = '{9'd284, 3'sd3, 8'd35};
                5'd14:   e = '{9'd451, 3'sd2, 8'd35};
                5'd15:   e = '{9'd268, 3'sd1, 8'd70};
                5'd16:   e = '{9'd451, 3'sd0, 8'd70};
                5'd17:   e = '{9'd253, 3'sd2, 8'd70};
                5'd18:   e = '{9'd338, 3'sd0, 8'd140};
                5'd19:   e = '{9'd268, 3'sd3, 8'd140};
                5'd20:   e = '{9'd301, 3'sd1, 8'd140};
                default: e = '0;
            endcase
        end
        return e;
    endfunction

    // octave shift, kept to 12 bits
    function automatic logic [11:0] note_period(input t_entry e);
        logic [11:0] p;
        logic [2:0]  mag;
        p   = {3'd0, e.period};
        mag = 3'(~e.octave + 3'sd1);
        if (e.octave >= 0) begin
            p = p << e.octave[1:0];
        end else begin
            p = p >> mag;
        end
        return p;
    endfunction

endpackage

[hw/rtl/tns_cmd_if.sv]
// command channel: valid, ready and the command payload
interface tns_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] elapsed;

    modport source (output valid, output cmd, output elapsed, input ready);
    modport sink   (input valid, input cmd, input elapsed, output ready);
endinterface

[hw/rtl/tns_note_if.sv]
// note channel: valid, ready and the tone generator payload
interface tns_note_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [11:0] tone_period;
    logic [3:0]  level;

    modport source (output valid, output action, output tone_period, output level,
                    input ready);
    modport sink   (input valid, input action, input tone_period, input level,
                    output ready);
endinterface

[hw/rtl/tns_in_stage.sv]
// input register stage for command transactions
module tns_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tns_cmd_if.sink        i_cmd_ch,
    output logic           o_valid,
    output tns_pkg::t_item o_item,
    input  logic           i_ready
);

    logic           r_valid;
    logic           n_valid;
    tns_pkg::t_item r_item;
    logic           take;

    assign i_cmd_ch.ready = !r_valid || i_ready;
    assign take           = i_cmd_ch.valid && i_cmd_ch.ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= '{cmd: i_cmd_ch.cmd, elapsed: i_cmd_ch.elapsed};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/tns_engine.sv]
// sequencer state, per-command update and result register
module tns_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tns_pkg::t_item i_item,
    output logic           o_ready,
    input  logic [3:0]     i_volume,
    tns_note_if.source     o_note_ch
);

    logic [tns_pkg::POS_W-1:0]  r_position, n_position;
    logic [tns_pkg::HOLD_W-1:0] r_hold_left, n_hold_left;
    logic                       r_paused, n_paused;
    logic                       r_silenced, n_silenced;
    logic                       r_out_valid, n_out_valid;
    tns_pkg::t_action           r_action, n_action;
    logic [11:0]                r_period, n_period;
    logic [3:0]                 r_level, n_level;

    logic                       fire;
    logic [tns_pkg::POS_W:0]    pos_inc;
    logic [tns_pkg::POS_W-1:0]  pos_next;
    tns_pkg::t_entry            entry_cur;
    tns_pkg::t_entry            entry_next;
    logic [tns_pkg::HOLD_W-1:0] elapsed_ext;

    assign o_ready = !r_out_valid || o_note_ch.ready;
    assign fire    = i_valid && o_ready;

    assign pos_inc     = {1'b0, r_position} + 1'b1;
    assign pos_next    = (pos_inc == (tns_pkg::POS_W+1)'(tns_pkg::TUNE_LENGTH)) ?
                         '0 : pos_inc[tns_pkg::POS_W-1:0];
    assign entry_cur   = tns_pkg::tune_entry(r_position);
    assign entry_next  = tns_pkg::tune_entry(pos_next);
    assign elapsed_ext = tns_pkg::HOLD_W'(i_item.elapsed);

    always_comb begin
        n_position  = r_position;
        n_hold_left = r_hold_left;
        n_paused    = r_paused;
        n_silenced  = r_silenced;
        n_out_valid = r_out_valid;
        n_action    = r_action;
        n_period    = r_period;
        n_level     = r_level;
        if (o_note_ch.ready) begin
            n_out_valid = 1'b0;
        end
        if (fire) begin
            n_out_valid = 1'b1;
            n_action    = tns_pkg::ACT_NONE;
            n_period    = '0;
            n_level     = '0;
            unique case (tns_pkg::t_cmd'(i_item.cmd))
                tns_pkg::CMD_TICK: begin
                    if (!r_paused) begin
                        if (elapsed_ext >= r_hold_left) begin
                            n_position  = pos_next;
                            n_action    = tns_pkg::ACT_LOAD;
                            n_period    = tns_pkg::note_period(entry_next);
                            n_level     = i_volume;
                            n_hold_left = tns_pkg::HOLD_W'(entry_next.duration);
                        end else if (r_silenced) begin
                            n_action    = tns_pkg::ACT_LOAD;
                            n_period    = tns_pkg::note_period(entry_cur);
                            n_level     = i_volume;
                            n_hold_left = tns_pkg::HOLD_W'(entry_cur.duration);
                            n_silenced  = 1'b0;
                        end else begin
                            n_hold_left = r_hold_left - elapsed_ext;
                        end
                    end else if (!r_silenced) begin
                        n_action   = tns_pkg::ACT_SILENCE;
                        n_silenced = 1'b1;
                    end
                end
                tns_pkg::CMD_START: begin
                    n_position = '0;
                    n_paused   = 1'b0;
                end
                tns_pkg::CMD_PAUSE:  n_paused = 1'b1;
                tns_pkg::CMD_RESUME: n_paused = 1'b0;
                tns_pkg::CMD_STOP: begin
                    n_position = '0;
                    n_paused   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_hold_left <= '1;
            r_paused    <= 1'b1;
            r_silenced  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_position  <= n_position;
            r_hold_left <= n_hold_left;
            r_paused    <= n_paused;
            r_silenced  <= n_silenced;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_period <= n_period;
        r_level  <= n_level;
    end

    assign o_note_ch.valid       = r_out_valid;
    assign o_note_ch.action      = r_action;
    assign o_note_ch.tone_period = r_period;
    assign o_note_ch.level       = r_level;

endmodule

[hw/rtl/tune_note_sequencer_top.sv]
// top level of the tune note sequencer
//
//  channel    | dir | payload                          | transfer
//  i_cmd_ch   | in  | cmd[2:0], elapsed[15:0]          | valid && ready
//  o_note_ch  | out | action[1:0], tone_period[11:0],  | valid && ready
//             |     | level[3:0]                       |
//  i_cfg_*    | in  | volume[3:0]                      | i_cfg_we
//
// each command transaction passes from acceptance through the input register,
// then through the state update into the result register; the 32-bit hold
// compare and subtract set the path between them
// a new command is accepted every cycle while the result side keeps up
// synchronous active-low reset: stopped at position 0, paused, silenced,
// hold at all ones, volume 11
// when the result register is not taken, the input register fills and
// then ready drops; nothing is lost or repeated
module tune_note_sequencer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tns_cmd_if.sink    i_cmd_ch,
    tns_note_if.source o_note_ch,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    // volume register, to be written only while idle; the block does not enforce this
    logic [3:0]     r_volume;
    logic [3:0]     n_volume;

    // link from the input register to the engine
    logic           stage_valid;
    tns_pkg::t_item stage_item;
    logic           engine_ready;

    assign n_volume = i_cfg_we ? i_cfg_wdata : r_volume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= 4'd11;
        end else begin
            r_volume <= n_volume;
        end
    end

    // input register
    tns_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (i_cmd_ch),
        .o_valid  (stage_valid),
        .o_item   (stage_item),
        .i_ready  (engine_ready)
    );

    // state update and result register
    tns_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid),
        .i_item    (stage_item),
        .o_ready   (engine_ready),
        .i_volume  (r_volume),
        .o_note_ch (o_note_ch)
    );

endmodule
